// ===== rtl/core/rgam_pkg.sv =====
package rgam_pkg;

	// Sizing of the lane set and of each lane's frame ring.
	localparam int NUM_LANES   = 4;
	localparam int RING_FRAMES = 4096;
	localparam int LANE_W      = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int RING_AW     = $clog2(RING_FRAMES);
	localparam int CNT_W       = $clog2(RING_FRAMES + 1);
	localparam int MEM_DEPTH   = NUM_LANES * RING_FRAMES;
	localparam int MEM_AW      = $clog2(MEM_DEPTH);

	// Datapath widths.
	localparam int POS_W    = 32;
	localparam int GAIN_W   = 32;
	localparam int RATIO_W  = 20;
	localparam int RATE_W   = 18;
	localparam int ACC_W    = 18 + LANE_W;
	localparam int APB_AW   = 3;

	// Serial divider sizing.
	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 24;
	localparam int DCNT_W    = $clog2(DIV_NUM_W + 1);

	// Fixed constants.
	localparam int RATE_MIN   = 8000;
	localparam int RATE_MAX   = 192000;
	localparam int RATE_RESET = 48000;
	localparam int Q16_ONE    = 65536;
	localparam int DEFAULT_MS = 20;
	localparam int MS_DIV     = 1000;
	localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 32'sd1073741824;

	// Division of ms times rate by 1000: drop three bits, then multiply by the
	// reciprocal of 125 scaled by 2^38. Exact for every ms and rate in range.
	localparam logic [31:0] MS_RECIP    = 32'd2199023256;
	localparam int          MS_RECIP_SH = 38;

	// Request codes.
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_RAMP = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Register indexes.
	localparam logic REG_OUTPUT_RATE = 1'b0;

	// Source formats: sample rate and mono flag.
	localparam logic [15:0] FMT_RATE [8] = '{16'd44100, 16'd44100, 16'd44100, 16'd8000,
		16'd48000, 16'd16000, 16'd24000, 16'd16000};
	localparam logic [7:0] FMT_MONO = 8'b0110_1000;

	// Step ratios at the reset output rate.
	localparam logic [RATIO_W-1:0] RATIO_RESET [8] = '{
		RATIO_W'(((64'd44100 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd44100 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd44100 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd8000 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd48000 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd16000 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd24000 << 16) + RATE_RESET / 2) / RATE_RESET),
		RATIO_W'(((64'd16000 << 16) + RATE_RESET / 2) / RATE_RESET)};

	// Per-lane state word kept in the lane memory.
	typedef struct packed {
		logic [RING_AW-1:0]        head;
		logic [CNT_W-1:0]          count;
		logic [POS_W-1:0]          pos;
		logic [2:0]                fmt;
		logic signed [GAIN_W-1:0]  gain;
		logic signed [GAIN_W-1:0]  target;
		logic signed [GAIN_W-1:0]  step;
	} lane_st_t;

	localparam int LS_W = $bits(lane_st_t);

	localparam lane_st_t LS_RESET = '{head: '0, count: '0, pos: '0, fmt: 3'd1,
		gain: UNITY_GAIN, target: UNITY_GAIN, step: '0};

	// Divider request.
	typedef struct packed {
		logic                  start;
		logic [DIV_NUM_W-1:0]  num;
		logic [DIV_DEN_W-1:0]  den;
	} div_req_t;

	// A cleared lane with a new format.
	function automatic lane_st_t lane_clear(input logic [2:0] f);
		lane_st_t c;
		c = LS_RESET;
		c.fmt = f;
		return c;
	endfunction

	// Ring slot at an offset from the head, wrapped.
	function automatic logic [RING_AW-1:0] ring_wrap(input logic [RING_AW-1:0] h,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(RING_FRAMES)) begin
			s = s - (CNT_W+1)'(RING_FRAMES);
		end
		return s[RING_AW-1:0];
	endfunction

	// Sample memory address of a lane's ring slot.
	function automatic logic [MEM_AW-1:0] ring_addr(input logic [LANE_W-1:0] k,
		input logic [RING_AW-1:0] h, input logic [CNT_W-1:0] off);
		return MEM_AW'(k) * MEM_AW'(RING_FRAMES) + MEM_AW'(ring_wrap(h, off));
	endfunction

endpackage

// ===== rtl/core/rgam_ram.sv =====
module rgam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/rgam_div.sv =====
module rgam_div import rgam_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	output logic                  busy,
	output logic [DIV_NUM_W-1:0]  quo
);

	logic                  busy_q;
	logic [DCNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [DIV_DEN_W-1:0]  rem_q;
	logic [DIV_NUM_W-1:0]  quo_q;
	logic [DIV_DEN_W:0]    trial;
	logic                  ge;
	logic [DIV_DEN_W-1:0]  nrem;

	// One restoring step per cycle, quotient bits shift in behind the numerator.
	always_comb begin
		trial = {rem_q, quo_q[DIV_NUM_W-1]};
		ge = trial >= {1'b0, den_q};
		nrem = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= DCNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= nrem;
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule

// ===== rtl/core/resampling_gain_ramp_audio_mixer_unit.sv =====
// Four-lane stereo mixer with linear-interpolation resampling and gain ramps. Lane state
// (ring head and count, Q16 read position, format, Q2.30 gain, target and step) sits in a
// small lane memory; source frames sit in one shared sample memory with one ring per lane.
// A push or a ramp is a read-modify-write of one lane's state word, and a tick does the
// same for every lane, visiting them one after another with two sample memory reads each
// (none for a lane with no frame at its position). A ramp takes its length from a
// reciprocal multiplication and its step from one pass through the serial divider. A
// write of output_rate that arrives while idle recomputes the eight per-format step
// ratios on the same divider, and requests stall meanwhile. A finished tick result
// waits in an output register while the next request is taken.
module resampling_gain_ramp_audio_mixer_unit import rgam_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [1:0]           lane,
	input  logic [2:0]           format_code,
	input  logic signed [15:0]   sample_left,
	input  logic signed [15:0]   sample_right,
	input  logic signed [17:0]   volume,
	input  logic [15:0]          ramp_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   out_left,
	output logic signed [15:0]   out_right,
	output logic                 has_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LREAD  = 4'd1;
	localparam logic [3:0] ST_LDATA  = 4'd2;
	localparam logic [3:0] ST_PUSH   = 4'd3;
	localparam logic [3:0] ST_RAMP0  = 4'd4;
	localparam logic [3:0] ST_RAMP1  = 4'd5;
	localparam logic [3:0] ST_RAMP2  = 4'd6;
	localparam logic [3:0] ST_T_GAIN = 4'd7;
	localparam logic [3:0] ST_T_F0   = 4'd8;
	localparam logic [3:0] ST_T_F1   = 4'd9;
	localparam logic [3:0] ST_T_MUL1 = 4'd10;
	localparam logic [3:0] ST_T_MUL2 = 4'd11;
	localparam logic [3:0] ST_T_RND  = 4'd12;
	localparam logic [3:0] ST_T_POS  = 4'd13;
	localparam logic [3:0] ST_T_OUT  = 4'd14;
	localparam logic [3:0] ST_RATIO  = 4'd15;

	logic [3:0]                state_q;
	logic [LANE_W-1:0]         cur_q;
	logic [1:0]                mode_q;
	logic [2:0]                fmt_q;
	logic [15:0]               left_q;
	logic [15:0]               right_q;
	logic signed [17:0]        vol_q;
	logic [15:0]               ms_q;
	lane_st_t                  ls_q;
	logic                      any_q;
	logic signed [ACC_W-1:0]   acc_l_q;
	logic signed [ACC_W-1:0]   acc_r_q;
	logic [CNT_W-1:0]          i1_q;
	logic [31:0]               f0_q;
	logic signed [31:0]        s_l_q;
	logic signed [31:0]        s_r_q;
	logic signed [63:0]        p_l_q;
	logic signed [63:0]        p_r_q;
	logic                      neg_q;
	logic [33:0]               ms_rate_q;
	logic [DIV_DEN_W-1:0]      frames_q;
	logic [RATE_W-1:0]         rate_q;
	logic [RATIO_W-1:0]        ratio_q [8];
	logic [2:0]                fi_q;
	logic                      ratio_run_q;
	logic [NUM_LANES-1:0]      lane_vld_q;
	logic                      out_valid_q;
	logic [15:0]               out_l_q;
	logic [15:0]               out_r_q;
	logic                      out_hd_q;

	logic                      accept;
	logic                      cfg_wr;
	logic                      cfg_idx;
	logic [RATE_W-1:0]         rate_new;
	logic                      out_load;

	logic                      ls_we;
	logic                      ls_re;
	lane_st_t                  ls_wdata;
	logic [LS_W-1:0]           ls_rdata;
	lane_st_t                  ls_cur;
	logic                      ring_we;
	logic                      ring_re;
	logic [MEM_AW-1:0]         ring_waddr;
	logic [MEM_AW-1:0]         ring_raddr;
	logic [31:0]               ring_wdata;
	logic [31:0]               ring_rdata;

	div_req_t                  div_req;
	logic                      div_busy;
	logic [DIV_NUM_W-1:0]      div_quo;

	lane_st_t                  push_st;
	lane_st_t                  pos_st;
	logic [15:0]               ms_eff;
	logic [33:0]               ms_rate;
	logic [62:0]               recip_prod;
	logic [17:0]               vol_clamp;
	logic signed [GAIN_W-1:0]  tgt_new;
	logic [DIV_DEN_W-1:0]      frames;
	logic signed [GAIN_W:0]    diff;
	logic [GAIN_W:0]           mag;
	logic signed [GAIN_W:0]    g_sum;
	logic signed [GAIN_W-1:0]  g_new;
	logic [15:0]               i0;
	logic                      hit;
	logic [CNT_W-1:0]          i1;
	logic [16:0]               frac_w;
	logic signed [33:0]        s_l;
	logic signed [33:0]        s_r;
	logic signed [17:0]        r_l;
	logic signed [17:0]        r_r;
	logic [CNT_W-1:0]          cons;
	logic signed [GAIN_W-1:0]  step_new;

	// Saturate a mixed sum to 16 bits.
	function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
		if (v > $signed(ACC_W'(32767))) begin
			return 16'h7fff;
		end else if (v < -$signed(ACC_W'(32768))) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// Round a Q46 product half away from zero.
	function automatic logic signed [17:0] round46(input logic signed [63:0] p);
		logic signed [63:0] b;
		b = p + (p[63] ? 64'sh1fff_ffff_ffff : 64'sh2000_0000_0000);
		return b[63:46];
	endfunction

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[APB_AW-1];
	assign prdata = (cfg_idx == REG_OUTPUT_RATE) ? 32'(rate_q) : '0;

	always_comb begin
		if (pwdata[RATE_W-1:0] < RATE_W'(RATE_MIN)) begin
			rate_new = RATE_W'(RATE_MIN);
		end else if (pwdata[RATE_W-1:0] > RATE_W'(RATE_MAX)) begin
			rate_new = RATE_W'(RATE_MAX);
		end else begin
			rate_new = pwdata[RATE_W-1:0];
		end
	end

	assign in_stall = (state_q != ST_IDLE) || cfg_wr;
	assign accept = in_valid && !in_stall;
	assign out_load = (state_q == ST_T_OUT) && (!out_valid_q || !out_stall);

	// Lane state as read, with never-written lanes at their reset value.
	assign ls_cur = lane_vld_q[cur_q] ? lane_st_t'(ls_rdata) : LS_RESET;

	// Push: drop the oldest frame of a full ring, then append.
	always_comb begin
		push_st = ls_q;
		if (ls_q.count >= CNT_W'(RING_FRAMES)) begin
			push_st.head = ring_wrap(ls_q.head, CNT_W'(1));
			push_st.count = CNT_W'(RING_FRAMES - 1);
			push_st.pos = (ls_q.pos > POS_W'(Q16_ONE)) ? ls_q.pos - POS_W'(Q16_ONE) : '0;
		end
	end

	// Ramp length and target.
	always_comb begin
		ms_eff = (ms_q == '0) ? 16'(DEFAULT_MS) : ms_q;
		ms_rate = 34'(ms_eff) * 34'(rate_q);
		recip_prod = 63'(ms_rate_q[33:3]) * 63'(MS_RECIP);
		if (vol_q < 0) begin
			vol_clamp = '0;
		end else if (vol_q > 18'sd65536) begin
			vol_clamp = 18'd65536;
		end else begin
			vol_clamp = vol_q;
		end
		tgt_new = GAIN_W'({vol_clamp, 14'b0});
		frames = (frames_q == '0) ? DIV_DEN_W'(1) : frames_q;
		diff = {ls_q.target[GAIN_W-1], ls_q.target} - {ls_q.gain[GAIN_W-1], ls_q.gain};
		mag = diff[GAIN_W] ? (GAIN_W+1)'(0) - diff : diff;
		step_new = neg_q ? -GAIN_W'(div_quo) : GAIN_W'(div_quo);
	end

	// Gain advance with clamping at the target.
	always_comb begin
		g_sum = {ls_q.gain[GAIN_W-1], ls_q.gain} + {ls_q.step[GAIN_W-1], ls_q.step};
		if ((ls_q.step > 0 && g_sum > $signed({ls_q.target[GAIN_W-1], ls_q.target}))
			|| (ls_q.step < 0 && g_sum < $signed({ls_q.target[GAIN_W-1], ls_q.target}))) begin
			g_new = ls_q.target;
		end else begin
			g_new = g_sum[GAIN_W-1:0];
		end
	end

	// Sample positions and interpolation.
	always_comb begin
		i0 = ls_q.pos[31:16];
		hit = 32'(i0) < 32'(ls_q.count);
		i1 = (32'(i0) + 32'd1 < 32'(ls_q.count)) ? CNT_W'(i0) + 1'b1 : CNT_W'(i0);
		frac_w = 17'(Q16_ONE) - {1'b0, ls_q.pos[15:0]};
		s_l = $signed(f0_q[15:0]) * $signed({1'b0, frac_w})
			+ $signed(ring_rdata[15:0]) * $signed({2'b0, ls_q.pos[15:0]});
		s_r = $signed(f0_q[31:16]) * $signed({1'b0, frac_w})
			+ $signed(ring_rdata[31:16]) * $signed({2'b0, ls_q.pos[15:0]});
		r_l = round46(p_l_q);
		r_r = round46(p_r_q);
	end

	// Retire whole frames passed by the read position.
	always_comb begin
		pos_st = ls_q;
		cons = (32'(ls_q.pos[31:16]) > 32'(ls_q.count)) ? ls_q.count : CNT_W'(ls_q.pos[31:16]);
		pos_st.head = ring_wrap(ls_q.head, cons);
		pos_st.count = ls_q.count - cons;
		pos_st.pos = ls_q.pos - (POS_W'(cons) << 16);
	end

	// Memory and divider requests per state.
	always_comb begin
		ls_re = (state_q == ST_LREAD);
		ls_we = 1'b0;
		ls_wdata = ls_q;
		ring_we = 1'b0;
		ring_waddr = ring_addr(cur_q, push_st.head, push_st.count);
		ring_wdata = {(FMT_MONO[fmt_q] ? left_q : right_q), left_q};
		ring_re = 1'b0;
		ring_raddr = ring_addr(cur_q, ls_q.head, CNT_W'(i0));
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		case (state_q)
			ST_PUSH: begin
				ring_we = 1'b1;
				ls_we = 1'b1;
				ls_wdata = push_st;
				ls_wdata.count = push_st.count + 1'b1;
			end
			ST_RAMP1: begin
				div_req.start = !div_busy;
				div_req.num = DIV_NUM_W'(mag) + DIV_NUM_W'(frames) - DIV_NUM_W'(1);
				div_req.den = frames;
			end
			ST_RAMP2: begin
				ls_we = !div_busy;
				ls_wdata.step = step_new;
			end
			ST_T_GAIN: begin
				ring_re = hit;
			end
			ST_T_F0: begin
				ring_re = 1'b1;
				ring_raddr = ring_addr(cur_q, ls_q.head, i1_q);
			end
			ST_T_POS: begin
				ls_we = 1'b1;
				ls_wdata = pos_st;
			end
			ST_RATIO: begin
				div_req.start = !ratio_run_q;
				div_req.num = DIV_NUM_W'({FMT_RATE[fi_q], 16'b0}) + DIV_NUM_W'(rate_q >> 1);
				div_req.den = DIV_DEN_W'(rate_q);
			end
			default: begin
			end
		endcase
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= '0;
			rate_q <= RATE_W'(RATE_RESET);
			for (int i = 0; i < 8; i++) begin
				ratio_q[i] <= RATIO_RESET[i];
			end
			fi_q <= '0;
			ratio_run_q <= 1'b0;
			lane_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && cfg_idx == REG_OUTPUT_RATE) begin
				rate_q <= rate_new;
			end
			if (ls_we) begin
				lane_vld_q[cur_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_wr && cfg_idx == REG_OUTPUT_RATE) begin
						state_q <= ST_RATIO;
						fi_q <= '0;
						ratio_run_q <= 1'b0;
					end else if (accept) begin
						if (mode == MODE_TICK) begin
							cur_q <= '0;
							state_q <= ST_LREAD;
						end else if ((mode == MODE_PUSH || mode == MODE_RAMP)
							&& 32'(lane) < NUM_LANES) begin
							cur_q <= LANE_W'(lane);
							state_q <= ST_LREAD;
						end
					end
				end
				ST_LREAD: state_q <= ST_LDATA;
				ST_LDATA: begin
					if (mode_q == MODE_PUSH) begin
						state_q <= ST_PUSH;
					end else if (mode_q == MODE_RAMP) begin
						state_q <= ST_RAMP0;
					end else begin
						state_q <= ST_T_GAIN;
					end
				end
				ST_PUSH: state_q <= ST_IDLE;
				ST_RAMP0: state_q <= ST_RAMP1;
				ST_RAMP1: begin
					if (!div_busy) begin
						state_q <= ST_RAMP2;
					end
				end
				ST_RAMP2: begin
					if (!div_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_T_GAIN: state_q <= hit ? ST_T_F0 : ST_T_POS;
				ST_T_F0: state_q <= ST_T_F1;
				ST_T_F1: state_q <= ST_T_MUL1;
				ST_T_MUL1: state_q <= ST_T_MUL2;
				ST_T_MUL2: state_q <= ST_T_RND;
				ST_T_RND: state_q <= ST_T_POS;
				ST_T_POS: begin
					if (cur_q == LANE_W'(NUM_LANES - 1)) begin
						state_q <= ST_T_OUT;
					end else begin
						cur_q <= cur_q + 1'b1;
						state_q <= ST_LREAD;
					end
				end
				ST_T_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RATIO: begin
					if (!ratio_run_q) begin
						ratio_run_q <= 1'b1;
					end else if (!div_busy) begin
						ratio_q[fi_q] <= div_quo[RATIO_W-1:0];
						ratio_run_q <= 1'b0;
						fi_q <= fi_q + 1'b1;
						if (fi_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request fields, lane working copy and mixing datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			fmt_q <= format_code;
			left_q <= sample_left;
			right_q <= sample_right;
			vol_q <= volume;
			ms_q <= ramp_ms;
			any_q <= 1'b0;
			acc_l_q <= '0;
			acc_r_q <= '0;
		end
		case (state_q)
			ST_LDATA: begin
				if (mode_q != MODE_TICK && fmt_q != ls_cur.fmt) begin
					ls_q <= lane_clear(fmt_q);
				end else begin
					ls_q <= ls_cur;
				end
				if (ls_cur.count != '0) begin
					any_q <= 1'b1;
				end
				ms_rate_q <= ms_rate;
			end
			ST_RAMP0: begin
				ls_q.target <= tgt_new;
				frames_q <= DIV_DEN_W'(recip_prod >> MS_RECIP_SH);
			end
			ST_RAMP1: neg_q <= diff[GAIN_W];
			ST_T_GAIN: begin
				ls_q.gain <= g_new;
				i1_q <= i1;
			end
			ST_T_F0: f0_q <= ring_rdata;
			ST_T_MUL1: begin
				s_l_q <= 32'(s_l);
				s_r_q <= 32'(s_r);
			end
			ST_T_MUL2: begin
				p_l_q <= 64'(s_l_q) * 64'(ls_q.gain);
				p_r_q <= 64'(s_r_q) * 64'(ls_q.gain);
			end
			ST_T_RND: begin
				acc_l_q <= acc_l_q + ACC_W'(r_l);
				acc_r_q <= acc_r_q + ACC_W'(r_r);
				ls_q.pos <= ls_q.pos + POS_W'(ratio_q[ls_q.fmt]);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_l_q <= sat16(acc_l_q);
			out_r_q <= sat16(acc_r_q);
			out_hd_q <= any_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left = out_l_q;
	assign out_right = out_r_q;
	assign has_data = out_hd_q;

	// Lane state memory.
	rgam_ram #(.WIDTH(LS_W), .DEPTH(NUM_LANES)) u_lane_ram (
		.clk   (clk),
		.we    (ls_we),
		.waddr (cur_q),
		.wdata (ls_wdata),
		.re    (ls_re),
		.raddr (cur_q),
		.rdata (ls_rdata)
	);

	// Source frame rings of all lanes.
	rgam_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Shared serial divider for ramps and step ratios.
	rgam_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// A tick result that finds the output register free is shown next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("tick result not loaded");

	// The divider is never restarted while working.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider restarted while busy");

	// A lane never holds more frames than its ring.
	a_lane_count: assert property (@(posedge clk) disable iff (!arst_n)
		ls_we |-> (ls_wdata.count <= CNT_W'(RING_FRAMES)))
		else $error("lane frame count overflow");

	// A frame is stored only together with its lane state update.
	a_ring_write: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> (ls_we && state_q == ST_PUSH))
		else $error("frame written outside a push");

endmodule

// ===== verif/tb_resampling_gain_ramp_audio_mixer_unit.sv =====
module tb_resampling_gain_ramp_audio_mixer_unit;
	import rgam_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] ADDR_OUTPUT_RATE = APB_AW'(4 * REG_OUTPUT_RATE);
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [1:0]         m;
		logic [1:0]         ln;
		logic [2:0]         f;
		logic signed [15:0] sl;
		logic signed [15:0] sr;
		logic signed [17:0] vol;
		logic [15:0]        ms;
	} mix_req_t;

	typedef struct {
		logic signed [15:0] l;
		logic signed [15:0] r;
		logic               hd;
	} mix_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_PUSH;
	logic [1:0] lane = '0;
	logic [2:0] format_code = 3'd1;
	logic signed [15:0] sample_left = '0;
	logic signed [15:0] sample_right = '0;
	logic signed [17:0] volume = '0;
	logic [15:0] ramp_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_left;
	logic signed [15:0] out_right;
	logic has_data;

	resampling_gain_ramp_audio_mixer_unit uut (.*);

	always #5 clk = ~clk;

	// Shadow of the mixer state.
	int unsigned rate_hz;
	int unsigned sh_head [4];
	int unsigned sh_count [4];
	longint unsigned sh_pos [4];
	longint unsigned sh_ratio [4];
	logic [2:0] sh_fmt [4];
	longint sh_gain [4];
	longint sh_target [4];
	longint sh_gstep [4];
	logic [31:0] sh_ring [4][RING_FRAMES];

	mix_req_t pending_reqs[$];
	mix_frame_t expected_frames[$];
	logic [2:0] gen_fmt [4];
	int errors = 0;

	function automatic longint unsigned ratio_of(logic [2:0] f);
		return ((longint'(FMT_RATE[f]) << 16) + rate_hz / 2) / rate_hz;
	endfunction

	function automatic void clear_lane(int k, logic [2:0] f);
		sh_head[k] = 0;
		sh_count[k] = 0;
		sh_pos[k] = 0;
		sh_fmt[k] = f;
		sh_ratio[k] = ratio_of(f);
		sh_gain[k] = longint'(UNITY_GAIN);
		sh_target[k] = longint'(UNITY_GAIN);
		sh_gstep[k] = 0;
	endfunction

	function automatic void set_rate(logic [31:0] v);
		int unsigned r;
		r = v[17:0];
		if (r < RATE_MIN) r = RATE_MIN;
		if (r > RATE_MAX) r = RATE_MAX;
		rate_hz = r;
		for (int k = 0; k < 4; k++) sh_ratio[k] = ratio_of(sh_fmt[k]);
	endfunction

	// Interpolate between two samples and scale by a Q2.30 gain, rounding half away from zero.
	function automatic longint lerp_gain(longint a, longint b, longint frac, longint g);
		longint s, p, mag, r;
		s = a * (65536 - frac) + b * frac;
		p = s * g;
		mag = (p < 0) ? -p : p;
		r = (mag + (64'sd1 <<< 45)) >>> 46;
		return (p < 0) ? -r : r;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		return v[15:0];
	endfunction

	// Apply one accepted request to the shadow state and queue any frame it yields.
	function automatic void mix_predict_request(mix_req_t q);
		int k;
		longint acc_l, acc_r, g, vol, diff, mag, stp, frames;
		longint unsigned i0, i1, avail, used;
		logic [31:0] f0, f1;
		logic [15:0] rs;
		bit any;
		mix_frame_t e;
		k = q.ln;
		if (q.m == MODE_PUSH || q.m == MODE_RAMP) begin
			if (q.f != sh_fmt[k]) clear_lane(k, q.f);
			if (q.m == MODE_PUSH) begin
				rs = FMT_MONO[q.f] ? q.sl : q.sr;
				if (sh_count[k] >= RING_FRAMES) begin
					sh_head[k] = (sh_head[k] + 1) % RING_FRAMES;
					sh_count[k] = RING_FRAMES - 1;
					sh_pos[k] = (sh_pos[k] > Q16_ONE) ? sh_pos[k] - Q16_ONE : 0;
				end
				sh_ring[k][(sh_head[k] + sh_count[k]) % RING_FRAMES] = {rs, q.sl};
				sh_count[k]++;
			end else begin
				vol = longint'(q.vol);
				if (vol < 0) vol = 0;
				if (vol > 65536) vol = 65536;
				sh_target[k] = vol <<< 14;
				frames = longint'((q.ms == 0) ? DEFAULT_MS : q.ms) * rate_hz / MS_DIV;
				if (frames < 1) frames = 1;
				diff = sh_target[k] - sh_gain[k];
				mag = (diff < 0) ? -diff : diff;
				stp = (mag + frames - 1) / frames;
				sh_gstep[k] = (diff < 0) ? -stp : stp;
			end
		end else if (q.m == MODE_TICK) begin
			acc_l = 0;
			acc_r = 0;
			any = 0;
			for (int j = 0; j < 4; j++) if (sh_count[j] != 0) any = 1;
			for (int j = 0; j < 4; j++) begin
				avail = sh_count[j];
				g = sh_gain[j] + sh_gstep[j];
				if ((sh_gstep[j] > 0 && g > sh_target[j]) ||
						(sh_gstep[j] < 0 && g < sh_target[j])) begin
					g = sh_target[j];
				end
				sh_gain[j] = g;
				i0 = sh_pos[j] >> 16;
				if (i0 < avail) begin
					i1 = (i0 + 1 < avail) ? i0 + 1 : i0;
					f0 = sh_ring[j][(sh_head[j] + i0) % RING_FRAMES];
					f1 = sh_ring[j][(sh_head[j] + i1) % RING_FRAMES];
					acc_l += lerp_gain(longint'($signed(f0[15:0])), longint'($signed(f1[15:0])),
						longint'(sh_pos[j] & 64'hFFFF), g);
					acc_r += lerp_gain(longint'($signed(f0[31:16])), longint'($signed(f1[31:16])),
						longint'(sh_pos[j] & 64'hFFFF), g);
					sh_pos[j] += sh_ratio[j];
				end
				used = sh_pos[j] >> 16;
				if (used > avail) used = avail;
				if (used > 0) begin
					sh_head[j] = (sh_head[j] + used) % RING_FRAMES;
					sh_count[j] -= used;
					sh_pos[j] -= used << 16;
				end
			end
			e.l = clip16(acc_l);
			e.r = clip16(acc_r);
			e.hd = any;
			expected_frames.push_back(e);
		end
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Request queue helpers.
	function automatic void add_req(logic [1:0] m, int ln, int f, int sl, int sr, int vol,
		int ms);
		mix_req_t q;
		q = '{m, 2'(ln), 3'(f), 16'(sl), 16'(sr), 18'(vol), 16'(ms)};
		if (m == MODE_PUSH || m == MODE_RAMP) gen_fmt[q.ln] = q.f;
		pending_reqs.push_back(q);
	endfunction

	function automatic void add_random(int n);
		int unsigned pick;
		logic [1:0] m, ln;
		logic [2:0] f;
		logic [17:0] vol;
		logic [15:0] ms;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			m = (pick < 55) ? MODE_PUSH : (pick < 85) ? MODE_TICK :
				(pick < 96) ? MODE_RAMP : MODE_UNUSED;
			ln = 2'($urandom_range(3));
			f = ($urandom_range(99) < 92) ? gen_fmt[ln] : 3'($urandom_range(7));
			vol = ($urandom_range(1) == 1) ? 18'($urandom_range(65536)) : 18'($urandom);
			pick = $urandom_range(9);
			ms = (pick < 6) ? 16'($urandom_range(1, 30)) : (pick < 8) ? 16'd0 : 16'($urandom);
			add_req(m, int'(ln), int'(f), int'(16'($urandom)), int'(16'($urandom)),
				int'(vol), int'(ms));
		end
	endfunction

	// Request driver: bursts of random length with random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		mix_req_t q;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				mix_predict_request('{mode, lane, format_code, sample_left, sample_right,
					volume, ramp_ms});
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					q = pending_reqs.pop_front();
					mode <= q.m;
					lane <= q.ln;
					format_code <= q.f;
					sample_left <= q.sl;
					sample_right <= q.sr;
					volume <= q.vol;
					ramp_ms <= q.ms;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(24);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with its own stall pattern.
	int unsigned stall_cyc = 0;
	always @(posedge clk) begin
		mix_frame_t e;
		stall_cyc++;
		case (stall_cyc[10:9])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(3) == 0);
			2'd2: out_stall <= ((stall_cyc % 16) < 11);
			default: out_stall <= ($urandom_range(1) == 0);
		endcase
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				flag_mismatch("unexpected frame, left", out_left, 0);
			end else begin
				e = expected_frames.pop_front();
				if (out_left !== e.l) flag_mismatch("out_left", out_left, e.l);
				if (out_right !== e.r) flag_mismatch("out_right", out_right, e.r);
				if (has_data !== e.hd) flag_mismatch("has_data", has_data, e.hd);
			end
		end
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Two-phase register write; the shadow follows at the write edge.
	task automatic write_rate(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_OUTPUT_RATE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		set_rate(v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		rate_hz = RATE_RESET;
		for (int k = 0; k < 4; k++) begin
			clear_lane(k, 3'd1);
			gen_fmt[k] = 3'd1;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: silence at reset, extremes, mono, tail, ramp clamps, format change.
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_PUSH, 0, 1, 16'h7FFF, 16'h8000, 0, 0);
		add_req(MODE_PUSH, 0, 1, 16'h8000, 16'h7FFF, 0, 0);
		add_req(MODE_PUSH, 1, 3, 16'h8000, 16'h1234, 0, 0);
		add_req(MODE_PUSH, 3, 1, 16'h7FFF, 16'h7FFF, 0, 0);
		add_req(MODE_PUSH, 2, 1, 16'h7FFF, 16'h7FFF, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_RAMP, 0, 1, 0, 0, 18'h20000, 16'd0);
		add_req(MODE_RAMP, 1, 3, 0, 0, 18'h1FFFF, 16'hFFFF);
		add_req(MODE_RAMP, 2, 1, 0, 0, 18'd32768, 16'd1);
		add_req(MODE_UNUSED, 2, 5, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 16'hFFFF);
		add_req(MODE_PUSH, 0, 1, 16'h4000, 16'hC000, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_RAMP, 3, 6, 0, 0, 18'd65536, 16'd5);
		add_req(MODE_PUSH, 3, 6, 16'h0100, 16'h5555, 0, 0);
		add_req(MODE_PUSH, 1, 7, 16'h0FFF, 16'hF000, 0, 0);
		add_req(MODE_PUSH, 2, 4, 16'h2AAA, 16'hD555, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		add_req(MODE_TICK, 0, 1, 0, 0, 0, 0);
		wait_idle();

		// Push a run of frames into one lane, interleaved with ticks that drain part of it.
		for (int i = 0; i < 24; i++)
			add_req(MODE_PUSH, 2, 0, int'(16'($urandom)), int'(16'($urandom)), 0, 0);
		for (int i = 0; i < 3; i++) add_req(MODE_TICK, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			add_req(MODE_PUSH, 2, 0, int'(16'($urandom)), int'(16'($urandom)), 0, 0);
		for (int i = 0; i < 12; i++) add_req(MODE_TICK, 0, 0, 0, 0, 0, 0);
		add_req(MODE_PUSH, 2, 5, 16'h1111, 16'h2222, 0, 0);
		add_random(160);
		wait_idle();

		// Random traffic across output rates, the clamped extremes among them.
		write_rate(32'd8000);
		add_random(160);
		wait_idle();
		write_rate(32'hFFFF_FFFF);
		add_random(160);
		wait_idle();
		write_rate(32'h5A5C_0003);
		add_random(100);
		wait_idle();
		write_rate(32'd192000);
		add_random(70);
		wait_idle();
		write_rate({14'($urandom), 18'($urandom_range(RATE_MIN, RATE_MAX))});
		add_random(130);
		wait_idle();

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
